// ----- sv/opphom_pkg.sv -----
package opphom_pkg;

    // default sizes
    localparam int SAMPLES_DEF   = 256;
    localparam int MARKERS_DEF   = 1024;
    localparam int WORD_BITS_DEF = 64;

    // field widths
    localparam int POS_W    = 31;
    localparam int REQ_W    = 2;
    localparam int CLASS_W  = 2;
    localparam int MIDX_W   = 10;
    localparam int SIDX_W   = 8;
    localparam int MCOUNT_W = 11;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_POS   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_GENO  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    // genotype classes
    localparam logic [CLASS_W-1:0] CLS_HOM_REF = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_HOM_ALT = 2'd2;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_MCOUNT = 2'd0;
    localparam logic [1:0] REG_CSTART = 2'd1;
    localparam logic [1:0] REG_CEND   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic write;
        logic start;
        logic scan;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;
        logic exhausted;
    } stat_t;

endpackage

// ----- sv/opphom_datapath.sv -----
module opphom_datapath #(
    parameter int SAMPLES   = opphom_pkg::SAMPLES_DEF,
    parameter int MARKERS   = opphom_pkg::MARKERS_DEF,
    parameter int WORD_BITS = opphom_pkg::WORD_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  opphom_pkg::cmd_t                    cmd,
    output opphom_pkg::stat_t                   stat,
    input  logic [opphom_pkg::REQ_W-1:0]        req_type,
    input  logic [opphom_pkg::MIDX_W-1:0]       marker_index,
    input  logic [opphom_pkg::SIDX_W-1:0]       first_sample,
    input  logic [opphom_pkg::SIDX_W-1:0]       second_sample,
    input  logic [opphom_pkg::CLASS_W-1:0]      genotype_class,
    input  logic [opphom_pkg::POS_W-1:0]        position_value,
    input  logic                                search_backward,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_idx,
    input  logic [31:0]                         cfg_wdata,
    output logic [31:0]                         cfg_rdata,
    output logic                                out_found,
    output logic [opphom_pkg::POS_W-1:0]        out_position
);

    localparam int SAMPLE_W    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    localparam int MARKER_W    = $clog2(MARKERS);
    localparam int WPS         = (MARKERS + WORD_BITS - 1) / WORD_BITS;
    localparam int PLANE_WORDS = SAMPLES * WPS;
    localparam int WADDR_W     = (PLANE_WORDS > 1) ? $clog2(PLANE_WORDS) : 1;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int N_W         = MARKER_W + 1;
    localparam int POS_W       = opphom_pkg::POS_W;

    // bit planes and positions
    logic [WORD_BITS-1:0] ref_mem [PLANE_WORDS];
    logic [WORD_BITS-1:0] alt_mem [PLANE_WORDS];
    logic [POS_W-1:0]     pos_mem [MARKERS];

    // configuration registers
    logic [opphom_pkg::MCOUNT_W-1:0] mcount_reg;
    logic [POS_W-1:0]                cstart_reg;
    logic [POS_W-1:0]                cend_reg;

    // query and scan state
    logic [SAMPLE_W-1:0] qa_reg, qb_reg;
    logic [POS_W-1:0]    qpos_reg;
    logic                qback_reg;
    logic [MARKER_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]      left_reg, left_next;
    logic                pv_reg, pv_next;
    logic [BIT_W-1:0]    pbit_reg;
    logic [WORD_BITS-1:0] rd_refa_reg, rd_refb_reg, rd_alta_reg, rd_altb_reg;
    logic [POS_W-1:0]    rd_pos_reg;
    logic                res_found_reg;
    logic [POS_W-1:0]    res_pos_reg;
    logic                out_found_reg;
    logic [POS_W-1:0]    out_pos_reg;

    logic [N_W-1:0]      n_use;
    logic [SAMPLE_W-1:0] ld_sample, st_a, st_b;
    logic [MARKER_W-1:0] ld_marker;
    logic [WADDR_W-1:0]  ld_addr, addr_a, addr_b;
    logic [BIT_W-1:0]    ld_bit;
    logic                issue, opp, pos_ok, hit;
    logic [POS_W-1:0]    clamped;

    // markers in use, limited to the store depth
    assign n_use = (mcount_reg > MARKERS) ? N_W'(MARKERS) : N_W'(mcount_reg);

    // load addressing, indices wrap on the store size
    assign ld_sample = SAMPLE_W'(first_sample % SAMPLES);
    assign st_a      = SAMPLE_W'(first_sample % SAMPLES);
    assign st_b      = SAMPLE_W'(second_sample % SAMPLES);
    assign ld_marker = MARKER_W'(marker_index % MARKERS);
    assign ld_addr   = WADDR_W'(ld_sample * WPS + ld_marker / WORD_BITS);
    assign ld_bit    = BIT_W'(ld_marker % WORD_BITS);

    // scan read addressing
    assign issue  = cmd.scan && (left_reg != '0);
    assign addr_a = WADDR_W'(qa_reg * WPS + cnt_reg / WORD_BITS);
    assign addr_b = WADDR_W'(qb_reg * WPS + cnt_reg / WORD_BITS);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mcount_reg <= '0;
            cstart_reg <= '0;
            cend_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_idx)
                opphom_pkg::REG_MCOUNT: mcount_reg <= cfg_wdata[opphom_pkg::MCOUNT_W-1:0];
                opphom_pkg::REG_CSTART: cstart_reg <= cfg_wdata[POS_W-1:0];
                opphom_pkg::REG_CEND:   cend_reg   <= cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // configuration readback
    always_comb begin
        case (cfg_idx)
            opphom_pkg::REG_MCOUNT: cfg_rdata = 32'(mcount_reg);
            opphom_pkg::REG_CSTART: cfg_rdata = 32'(cstart_reg);
            opphom_pkg::REG_CEND:   cfg_rdata = 32'(cend_reg);
            default:                cfg_rdata = '0;
        endcase
    end

    // memory writes and registered scan reads
    always_ff @(posedge aclk) begin
        if (cmd.write && req_type == opphom_pkg::REQ_POS) begin
            pos_mem[ld_marker] <= position_value;
        end
        if (cmd.write && req_type == opphom_pkg::REQ_GENO) begin
            ref_mem[ld_addr][ld_bit] <= (genotype_class == opphom_pkg::CLS_HOM_REF);
            alt_mem[ld_addr][ld_bit] <= (genotype_class == opphom_pkg::CLS_HOM_ALT);
        end
        if (issue) begin
            rd_refa_reg <= ref_mem[addr_a];
            rd_refb_reg <= ref_mem[addr_b];
            rd_alta_reg <= alt_mem[addr_a];
            rd_altb_reg <= alt_mem[addr_b];
            rd_pos_reg  <= pos_mem[cnt_reg];
            pbit_reg    <= BIT_W'(cnt_reg % WORD_BITS);
        end
    end

    // marker test on the word read last cycle
    assign opp = (rd_refa_reg[pbit_reg] ^ rd_refb_reg[pbit_reg]) &
                 (rd_alta_reg[pbit_reg] ^ rd_altb_reg[pbit_reg]);
    assign pos_ok = qback_reg ? (rd_pos_reg <= qpos_reg) : (rd_pos_reg >= qpos_reg);
    assign hit    = pv_reg && pos_ok && opp;

    // clamp to the centromere edge facing the start
    always_comb begin
        clamped = rd_pos_reg;
        if (qback_reg) begin
            if (cend_reg < qpos_reg && cend_reg > rd_pos_reg) clamped = cend_reg;
        end else begin
            if (cstart_reg > qpos_reg && cstart_reg < rd_pos_reg) clamped = cstart_reg;
        end
    end

    // scan counter
    always_comb begin
        cnt_next  = cnt_reg;
        left_next = left_reg;
        pv_next   = 1'b0;
        if (cmd.start) begin
            cnt_next  = search_backward ? MARKER_W'(n_use - N_W'(1)) : '0;
            left_next = n_use;
        end else if (issue) begin
            cnt_next  = qback_reg ? cnt_reg - MARKER_W'(1) : cnt_reg + MARKER_W'(1);
            left_next = left_reg - N_W'(1);
            pv_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg <= '0;
            pv_reg   <= 1'b0;
        end else begin
            left_reg <= left_next;
            pv_reg   <= pv_next;
        end
    end

    // query capture, result and output word
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        if (cmd.start) begin
            qa_reg        <= st_a;
            qb_reg        <= st_b;
            qpos_reg      <= position_value;
            qback_reg     <= search_backward;
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end else if (cmd.scan && hit) begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= clamped;
        end
        if (cmd.load_out) begin
            out_found_reg <= res_found_reg;
            out_pos_reg   <= res_pos_reg;
        end
    end

    assign stat.hit       = hit;
    assign stat.exhausted = (left_reg == '0) && !pv_reg;
    assign out_found      = out_found_reg;
    assign out_position   = out_pos_reg;

    // a new query never sees a read left over from the last one
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> !pv_reg)
        else $error("stale read after query start");

    // reads are issued only while scanning
    a_pv_from_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        pv_reg |-> $past(cmd.scan))
        else $error("read without scan");

    // remaining count never exceeds the store depth
    a_left_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        left_reg <= N_W'(MARKERS))
        else $error("scan count out of range");

endmodule

// ----- sv/opphom_ctrl.sv -----
module opphom_ctrl (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [opphom_pkg::REQ_W-1:0]  req_type,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output opphom_pkg::cmd_t              cmd,
    input  opphom_pkg::stat_t             stat
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;

    // next state and commands
    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        cmd           = '0;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    cmd.write = 1'b1;
                    if (req_type == opphom_pkg::REQ_QUERY) begin
                        cmd.start  = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (stat.hit || stat.exhausted) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.load_out  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // the output word is only overwritten once the old one is gone
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_tvalid_reg || m_tready))
        else $error("result word overwritten");

    // a query start always leads into the scan
    a_start_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |=> cmd.scan)
        else $error("query start without scan");

    // a scan ends only on a hit or when the markers run out
    a_scan_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN && !stat.hit && !stat.exhausted) |=> state_reg == ST_SCAN)
        else $error("scan left early");

endmodule

// ----- sv/opposite_homozygote_search.sv -----
// Opposite-homozygote search.
// Input stream (s_*): one word per request. s_tuser carries the request kind:
// marker position load, genotype class load, or search query. Loads give no
// result. A query gives exactly one result word on m_*: m_tuser says whether
// a marker was found, m_tdata holds its position (clamped to the centromere
// edge facing the start) or zero.
// A query walks the markers in use one per cycle, in index order forward or
// backward, reading both samples' bit plane words and the marker position
// from memory in the same cycle; it stops at the first opposite homozygote
// at or beyond the query position in the search direction. The next word can
// be taken in the cycle after the result is loaded.
// One request is handled at a time; loads are taken while a result waits,
// and a new query may start, but its result is held until the previous word
// is taken, so a stalled receiver stalls the input channel after that.
// Reset (aresetn low, synchronous) clears the configuration registers and the
// control state; memory contents are undefined until written. Registers must
// be written over the APB port only while the block is idle; it is unchecked.
module opposite_homozygote_search #(
    parameter int SAMPLES   = opphom_pkg::SAMPLES_DEF,
    parameter int MARKERS   = opphom_pkg::MARKERS_DEF,
    parameter int WORD_BITS = opphom_pkg::WORD_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // marker_index, first_sample, second_sample, genotype_class,
    // position_value, search_backward, zero fill
    input  logic [63:0] s_tdata,
    // req_type
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // found_position, zero fill
    output logic [31:0] m_tdata,
    // found
    output logic [0:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    opphom_pkg::cmd_t  cmd;
    opphom_pkg::stat_t stat;
    logic              out_found;
    logic [opphom_pkg::POS_W-1:0] out_position;
    logic              cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    // request sequencing
    opphom_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .req_type (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // stores, scan and result
    opphom_datapath #(
        .SAMPLES   (SAMPLES),
        .MARKERS   (MARKERS),
        .WORD_BITS (WORD_BITS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .req_type        (s_tuser),
        .marker_index    (s_tdata[9:0]),
        .first_sample    (s_tdata[17:10]),
        .second_sample   (s_tdata[25:18]),
        .genotype_class  (s_tdata[27:26]),
        .position_value  (s_tdata[58:28]),
        .search_backward (s_tdata[59]),
        .cfg_we          (cfg_we),
        .cfg_idx         (paddr[3:2]),
        .cfg_wdata       (pwdata),
        .cfg_rdata       (prdata),
        .out_found       (out_found),
        .out_position    (out_position)
    );

    assign m_tdata = {1'b0, out_position};
    assign m_tuser = out_found;

endmodule
